// File: rtl/core/vrt_pkg.sv
// Shared types and constants for the voxel ray traversal unit.
package vrt_pkg;

  localparam logic [1:0] RK_QUERY = 2'd0;
  localparam logic [1:0] RK_HIT   = 2'd1;
  localparam logic [1:0] RK_MISS  = 2'd2;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [31:0] TIME_MAX   = 32'hFFFF_FFFF;
  localparam logic [11:0] BUDGET_MAX = 12'd4095;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;   // saturated to 32 bits
  } div_rsp_t;

endpackage

// File: rtl/core/vrt_divider.sv
// Restoring radix-2 divider, one quotient bit a cycle, saturating to 32 bits.
module vrt_divider (
  input  logic              clk,
  input  logic              rst,
  input  vrt_pkg::div_req_t req,
  output vrt_pkg::div_rsp_t rsp
);

  logic [63:0] quot;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic        running;
  logic        done;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quot[63]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= 7'd64;
        quot    <= req.dividend;
        rem     <= '0;
        dvs     <= req.divisor;
      end else if (running) begin
        if (!trial[32]) begin
          rem  <= trial;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // The final quotient is the shifted value computed in the last step.
  logic [63:0] q_final;
  assign q_final  = quot;
  assign rsp.done = done;
  assign rsp.quot = (q_final[63:32] != 32'd0) ? vrt_pkg::TIME_MAX : q_final[31:0];

endmodule

// File: rtl/core/voxel_ray_traversal_unit.sv
// Top level of the voxel ray traversal unit: DDA sequencer around a shared divider.
//
//  channel | direction | handshake          | contents
//  s_axis  | in        | tvalid/tready      | tuser=kind, tdata=origin, dir, max_dist, occupied
//  m_axis  | out       | tvalid/tready      | tuser=result_kind, tdata=voxel, hit point, normal
//
// A start request runs six divisions one after another in the single shared divider: each
// is issued in ST_DIV and its quotient collected in ST_WAIT, a division on an axis with
// zero direction is skipped, and ST_STEP then forms the first query. An answer request for
// a miss takes the DDA step in ST_STEP, then forms the next query; a hit report does one
// multiply per axis in ST_HIT, registered before the add that saturates each coordinate.
// Reset (rst, synchronous) returns the block to idle with no ray active.
// s_axis_tready is low while a request is being worked on or a result is held
// waiting for m_axis_tready.
module voxel_ray_traversal_unit #(
  parameter int FRAC_BITS   = 16,
  parameter int VOXEL_BITS  = 16,
  parameter int STEP_FACTOR = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] start_x, [63:32] start_y, [95:64] start_z, [127:96] dir_x,
  // [159:128] dir_y, [191:160] dir_z, [217:192] max_dist, [218] occupied
  input  logic [223:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] voxel_x, [31:16] voxel_y, [47:32] voxel_z, [79:48] hit_point_x,
  // [111:80] hit_point_y, [143:112] hit_point_z, [145:144] normal_x,
  // [147:146] normal_y, [149:148] normal_z
  output logic [151:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // [1:0] result_kind
);

  localparam logic [63:0] ONE_FX = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FRAC_MASK = ONE_FX - 64'd1;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_WAIT  = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_HIT   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state;

  logic                  busy;
  logic signed [VOXEL_BITS-1:0] cur_voxel [3];
  logic [31:0]           boundary_time [3];
  logic [31:0]           crossing_step [3];
  logic                  step_sign [3];
  logic [31:0]           ray_time;
  logic [11:0]           step_count;
  logic [11:0]           step_budget;
  logic [25:0]           dist_limit;
  logic signed [31:0]    ray_origin [3];
  logic signed [31:0]    ray_dir [3];
  logic [1:0]            last_axis;
  logic [63:0]           dm [3];
  logic [2:0]            div_idx;    // 0..5: boundary x,y,z then crossing x,y,z
  logic [1:0]            hit_idx;
  logic                  pending_step;

  logic [1:0]            o_kind;
  logic [15:0]           o_vox [3];
  logic [31:0]           o_hp [3];
  logic [1:0]            o_nrm [3];

  vrt_pkg::div_req_t div_req;
  vrt_pkg::div_rsp_t div_rsp;

  vrt_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic s_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tuser  = o_kind;
  assign m_axis_tdata  = {2'b00, o_nrm[2], o_nrm[1], o_nrm[0], o_hp[2], o_hp[1], o_hp[0],
                          o_vox[2], o_vox[1], o_vox[0]};

  // Divider operand selection.
  logic [1:0] dax;
  logic [31:0] dmag;
  assign dax  = (div_idx >= 3'd3) ? 2'(div_idx - 3'd3) : div_idx[1:0];
  assign dmag = ray_dir[dax][31] ? 32'(-ray_dir[dax]) : ray_dir[dax];
  assign div_req.start    = (state == ST_DIV) && (ray_dir[dax] != 32'sd0);
  assign div_req.dividend = (div_idx >= 3'd3) ? (ONE_FX << FRAC_BITS)
                                              : (dm[dax] << FRAC_BITS);
  assign div_req.divisor  = dmag;

  // DDA axis choice: strict less-than, so x wins only when strictly smallest and a y-z tie goes to z.
  logic [1:0] ax;
  always_comb begin
    if (boundary_time[0] < boundary_time[1] && boundary_time[0] < boundary_time[2]) ax = 2'd0;
    else if (boundary_time[1] < boundary_time[2]) ax = 2'd1;
    else ax = 2'd2;
  end

  logic [32:0] bt_sum;
  assign bt_sum = {1'b0, boundary_time[ax]} + {1'b0, crossing_step[ax]};

  // Hit point: one 32x32 multiply per cycle, registered before the add.
  logic [31:0] hmag;
  logic [63:0] prod;
  logic [63:0] prod_q;
  logic        neg_q;
  logic [1:0]  hax_q;
  logic        prod_v;
  assign hmag = ray_dir[hit_idx][31] ? 32'(-ray_dir[hit_idx]) : ray_dir[hit_idx];
  assign prod = 64'(hmag) * 64'(ray_time);

  // The scaled offset can reach well beyond 32 bits before saturation.
  logic [55:0]        qmag;
  logic signed [57:0] qv;
  logic signed [57:0] hsum;
  always_comb begin
    if (neg_q) qmag = 56'((prod_q + FRAC_MASK) >> FRAC_BITS);
    else       qmag = 56'(prod_q >> FRAC_BITS);
    qv   = neg_q ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    hsum = 58'(ray_origin[hax_q]) + qv;
  end

  // Start-item decode.
  logic signed [31:0] in_s [3];
  logic signed [31:0] in_d [3];
  assign in_s[0] = s_axis_tdata[31:0];
  assign in_s[1] = s_axis_tdata[63:32];
  assign in_s[2] = s_axis_tdata[95:64];
  assign in_d[0] = s_axis_tdata[127:96];
  assign in_d[1] = s_axis_tdata[159:128];
  assign in_d[2] = s_axis_tdata[191:160];
  logic [25:0] in_max;
  assign in_max = s_axis_tdata[217:192];
  logic [31:0] budget_raw;
  assign budget_raw = 32'((64'(in_max) * 64'(STEP_FACTOR)) >> FRAC_BITS);

  logic walk_ok;
  assign walk_ok = (ray_time < 32'(dist_limit)) && (step_count < step_budget);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      last_axis <= vrt_pkg::AXIS_NONE;
      prod_v <= 1'b0;
      div_idx <= '0;
      hit_idx <= '0;
      pending_step <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser == vrt_pkg::KIND_START) begin
              for (int i = 0; i < 3; i++) begin
                logic [31:0] biased;
                biased = 32'(in_s[i]) ^ 32'h8000_0000;
                ray_origin[i] <= in_s[i];
                ray_dir[i]    <= in_d[i];
                cur_voxel[i]  <= VOXEL_BITS'(in_s[i] >>> FRAC_BITS);
                step_sign[i]  <= (in_d[i] > 32'sd0);
                dm[i] <= (in_d[i] > 32'sd0) ? (ONE_FX - (64'(biased) & FRAC_MASK))
                                            : (64'(biased) & FRAC_MASK);
                boundary_time[i] <= vrt_pkg::TIME_MAX;
                crossing_step[i] <= vrt_pkg::TIME_MAX;
              end
              ray_time    <= '0;
              step_count  <= '0;
              dist_limit  <= in_max;
              step_budget <= (budget_raw > 32'(vrt_pkg::BUDGET_MAX)) ? vrt_pkg::BUDGET_MAX
                                                                    : budget_raw[11:0];
              last_axis   <= vrt_pkg::AXIS_NONE;
              busy        <= 1'b1;
              div_idx     <= '0;
              state       <= ST_DIV;
            end else if (busy) begin
              if (s_axis_tdata[218]) begin
                hit_idx <= 2'd0;
                prod_v  <= 1'b0;
                o_kind  <= vrt_pkg::RK_HIT;
                // The normal points against the step on the last crossed axis.
                for (int i = 0; i < 3; i++) begin
                  o_vox[i] <= 16'(cur_voxel[i]);
                  o_nrm[i] <= (last_axis == 2'(i)) ? (step_sign[i] ? 2'b11 : 2'b01) : 2'b00;
                end
                busy  <= 1'b0;
                state <= ST_HIT;
              end else begin
                state <= ST_STEP;
              end
            end
          end
        end
        ST_DIV: begin
          if (ray_dir[dax] != 32'sd0) state <= ST_WAIT;
          else if (div_idx == 3'd5) begin
            pending_step <= 1'b1;
            state <= ST_STEP;
          end else div_idx <= div_idx + 3'd1;
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            if (div_idx >= 3'd3) crossing_step[dax] <= div_rsp.quot;
            else boundary_time[dax] <= div_rsp.quot;
            if (div_idx == 3'd5) begin
              pending_step <= 1'b1;
              state <= ST_STEP;
            end else begin
              div_idx <= div_idx + 3'd1;
              state <= ST_DIV;
            end
          end
        end
        ST_STEP: begin
          // Either the emit after setup (pending_step) or a DDA advance then emit.
          if (pending_step) begin
            pending_step <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              o_vox[i] <= walk_ok ? 16'(cur_voxel[i]) : 16'd0;
              o_hp[i]  <= '0;
              o_nrm[i] <= '0;
            end
            if (walk_ok) o_kind <= vrt_pkg::RK_QUERY;
            else begin
              o_kind <= vrt_pkg::RK_MISS;
              busy   <= 1'b0;
            end
            state <= ST_OUT;
          end else begin
            cur_voxel[ax] <= step_sign[ax] ? cur_voxel[ax] + VOXEL_BITS'(1)
                                           : cur_voxel[ax] - VOXEL_BITS'(1);
            ray_time <= boundary_time[ax];
            boundary_time[ax] <= bt_sum[32] ? vrt_pkg::TIME_MAX : bt_sum[31:0];
            last_axis <= ax;
            if (step_count < vrt_pkg::BUDGET_MAX) step_count <= step_count + 12'd1;
            pending_step <= 1'b1;
          end
        end
        ST_HIT: begin
          prod_q <= prod;
          neg_q  <= ray_dir[hit_idx][31];
          hax_q  <= hit_idx;
          prod_v <= 1'b1;
          if (prod_v) begin
            if (hsum > 58'sd2147483647) o_hp[hax_q] <= 32'h7FFF_FFFF;
            else if (hsum < -58'sd2147483648) o_hp[hax_q] <= 32'h8000_0000;
            else o_hp[hax_q] <= hsum[31:0];
          end
          if (prod_v && hax_q == 2'd2) state <= ST_OUT;
          else if (hit_idx != 2'd2) hit_idx <= hit_idx + 2'd1;
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A miss report carries nothing but its kind.
  a_miss_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == vrt_pkg::RK_MISS) |-> (m_axis_tdata == '0))
    else $error("miss report with payload");

  // No request is accepted while a result is held.
  a_no_accept_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("accepted while result pending");

  // A query never carries a face normal.
  a_query_nrm: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == vrt_pkg::RK_QUERY) |-> (m_axis_tdata[149:144] == '0))
    else $error("query with normal");

endmodule
